>>> hdl/pre_pkg.sv
// Package for the permutation rearrangement engine: sizes, opcodes and
// address helpers. No dependencies; used by the top level.
package pre_pkg;

	localparam int MAX_ELEMENTS = 64;
	localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
	localparam int POS_W        = 7;
	localparam int VAL_W        = 8;
	localparam int OP_W         = 3;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_W        = 7;

	localparam logic [CFG_IDX_W-1:0] REG_PERM_SIZE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 1'd1;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD     = 3'd0,
		OP_READ     = 3'd1,
		OP_REV      = 3'd2,
		OP_PRE_REV  = 3'd3,
		OP_SUF_REV  = 3'd4,
		OP_TRANSP   = 3'd5,
		OP_PRE_TRSP = 3'd6,
		OP_SUF_TRSP = 3'd7
	} opcode_t;

	// 1-based position or magnitude to a store address
	function automatic logic [ADDR_W-1:0] to_addr(input logic [VAL_W-1:0] p);
		logic [VAL_W-1:0] d;
		begin
			d = p - 8'd1;
			return d[ADDR_W-1:0];
		end
	endfunction

	// magnitude of a signed element, as unsigned
	function automatic logic [VAL_W-1:0] mag(input logic [VAL_W-1:0] v);
		return v[VAL_W-1] ? (~v + 8'd1) : v;
	endfunction

endpackage

>>> hdl/permutation_rearrangement_engine.sv
// Top level of the permutation rearrangement engine: element, inverse and
// scratch stores plus the sequencer. Depends on pre_pkg and pre_ram.
//
// Usage: a word is taken when start is high and busy is low; its result
// shows on read_value, read_inverse and status for one cycle with done high,
// and must be captured then, as the block cannot be stalled. Load and
// rejected words raise done straight from idle; a read first passes through
// ST_RDWAIT. A reversal or transposition first copies its range word by word
// to a scratch store, then writes it back in its new order one position per
// cycle, since each store has a single read and write port. The user must
// write size and signed mode through cfg_we/cfg_index/cfg_wdata only while
// the block is idle; the block itself does not enforce this.
module permutation_rearrangement_engine (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	output logic                                 done,
	input  logic [pre_pkg::OP_W-1:0]             opcode,
	input  logic [pre_pkg::POS_W-1:0]            pos_a,
	input  logic [pre_pkg::POS_W-1:0]            pos_b,
	input  logic [pre_pkg::POS_W-1:0]            pos_c,
	input  logic signed [pre_pkg::VAL_W-1:0]     load_value,
	output logic signed [pre_pkg::VAL_W-1:0]     read_value,
	output logic signed [pre_pkg::VAL_W-1:0]     read_inverse,
	output logic                                 status,
	input  logic                                 cfg_we,
	input  logic [pre_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pre_pkg::CFG_W-1:0]            cfg_wdata
);
	import pre_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RDWAIT, ST_COPY, ST_GAP, ST_MOVE, ST_FIN
	} state_t;

	state_t state_q;

	logic [POS_W-1:0] perm_size_q;
	logic             signed_mode_q;

	logic [POS_W-1:0] t_q, lo_q, hi_q, split_q, off_q, len_q;
	logic [VAL_W-1:0] sum_q;
	logic             rev_q, neg_q;

	logic             cp_v_s1, mv_v_s1;
	logic [POS_W-1:0] cp_pos_s1, mv_pos_s1;

	logic [VAL_W-1:0] elem_rdata, inv_rdata, scr_rdata;

	// decode of the incoming word
	opcode_t          op;
	logic             accept, bad_c, rev_c, load_we;
	logic [VAL_W-1:0] a8, b8, c8, n8, n1, lv_mag;
	logic [VAL_W-1:0] lo_c, hi_c, ii, jj, kk;

	assign op     = opcode_t'(opcode);
	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	always_comb begin
		a8     = {1'b0, pos_a};
		b8     = {1'b0, pos_b};
		c8     = {1'b0, pos_c};
		n8     = (perm_size_q > POS_W'(MAX_ELEMENTS)) ? VAL_W'(MAX_ELEMENTS)
		                                              : {1'b0, perm_size_q};
		n1     = n8 + 8'd1;
		lv_mag = mag(load_value);
		bad_c  = 1'b1;
		rev_c  = 1'b1;
		lo_c   = a8;
		hi_c   = b8;
		ii     = a8;
		jj     = b8;
		kk     = c8;
		unique case (op)
			OP_LOAD: begin
				bad_c = !(a8 >= 8'd1 && a8 <= n8 && lv_mag >= 8'd1 && lv_mag <= n8
				          && !(load_value[VAL_W-1] && !signed_mode_q));
			end
			OP_READ: begin
				bad_c = !(a8 >= 8'd1 && a8 <= n8);
			end
			OP_REV: begin
				bad_c = !(a8 >= 8'd1 && a8 <= b8 && b8 <= n8);
			end
			OP_PRE_REV: begin
				bad_c = !(b8 >= 8'd1 && b8 <= n8);
				lo_c  = 8'd1;
			end
			OP_SUF_REV: begin
				bad_c = !(b8 >= 8'd1 && b8 <= n8);
				lo_c  = b8;
				hi_c  = n8;
			end
			OP_TRANSP: begin
				bad_c = !(a8 >= 8'd1 && a8 < b8 && b8 < c8 && c8 <= n1);
				rev_c = 1'b0;
			end
			OP_PRE_TRSP: begin
				bad_c = !(b8 > 8'd1 && b8 < c8 && c8 <= n1);
				rev_c = 1'b0;
				ii    = 8'd1;
			end
			OP_SUF_TRSP: begin
				bad_c = !(a8 >= 8'd1 && a8 < b8 && b8 < n1);
				rev_c = 1'b0;
				kk    = n1;
			end
			default: begin
				bad_c = 1'b1;
			end
		endcase
		if (!rev_c) begin
			lo_c = ii;
			hi_c = kk - 8'd1;
		end
	end

	assign load_we = accept && (op == OP_LOAD) && !bad_c;

	// source position for the write-back pass
	logic [VAL_W-1:0] src;
	always_comb begin
		if (rev_q) begin
			src = sum_q - {1'b0, t_q};
		end else if (t_q < split_q) begin
			src = {1'b0, t_q} + {1'b0, off_q};
		end else begin
			src = {1'b0, t_q} - {1'b0, len_q};
		end
	end

	// write-back stage: value moved, optionally negated
	logic [VAL_W-1:0] mv_val, mv_mag, mv_pos8, mv_inv, ld_inv;
	logic             mv_inv_ok;
	always_comb begin
		mv_val    = (rev_q && neg_q) ? (8'd0 - scr_rdata) : scr_rdata;
		mv_mag    = mag(mv_val);
		mv_inv_ok = (mv_mag >= 8'd1) && (mv_mag <= VAL_W'(MAX_ELEMENTS));
		mv_pos8   = {1'b0, mv_pos_s1};
		mv_inv    = mv_val[VAL_W-1] ? (8'd0 - mv_pos8) : mv_pos8;
		ld_inv    = load_value[VAL_W-1] ? (8'd0 - a8) : a8;
	end

	logic              elem_we, inv_we;
	logic [ADDR_W-1:0] elem_waddr, elem_raddr, inv_waddr;
	logic [VAL_W-1:0]  elem_wdata, inv_wdata;

	assign elem_we    = load_we || mv_v_s1;
	assign elem_waddr = mv_v_s1 ? to_addr(mv_pos8) : to_addr(a8);
	assign elem_wdata = mv_v_s1 ? mv_val : load_value;
	assign elem_raddr = (state_q == ST_COPY) ? to_addr({1'b0, t_q}) : to_addr(a8);

	assign inv_we    = load_we || (mv_v_s1 && mv_inv_ok);
	assign inv_waddr = mv_v_s1 ? to_addr(mv_mag) : to_addr(lv_mag);
	assign inv_wdata = mv_v_s1 ? mv_inv : ld_inv;

	pre_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ELEMENTS)) u_elem (
		.clk   (clk),
		.we    (elem_we),
		.waddr (elem_waddr),
		.wdata (elem_wdata),
		.raddr (elem_raddr),
		.rdata (elem_rdata)
	);

	pre_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ELEMENTS)) u_inv (
		.clk   (clk),
		.we    (inv_we),
		.waddr (inv_waddr),
		.wdata (inv_wdata),
		.raddr (to_addr(a8)),
		.rdata (inv_rdata)
	);

	pre_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ELEMENTS)) u_scratch (
		.clk   (clk),
		.we    (cp_v_s1),
		.waddr (to_addr({1'b0, cp_pos_s1})),
		.wdata (elem_rdata),
		.raddr (to_addr(src)),
		.rdata (scr_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_size_q   <= POS_W'(MAX_ELEMENTS);
			signed_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PERM_SIZE:   perm_size_q   <= cfg_wdata;
				REG_SIGNED_MODE: signed_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// payload of the operation in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q    <= lo_c[POS_W-1:0];
			hi_q    <= hi_c[POS_W-1:0];
			sum_q   <= lo_c + hi_c;
			split_q <= POS_W'(ii + kk - jj);
			off_q   <= POS_W'(jj - ii);
			len_q   <= POS_W'(kk - jj);
			rev_q   <= rev_c;
			neg_q   <= signed_mode_q;
		end
		cp_pos_s1 <= t_q;
		mv_pos_s1 <= t_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			done         <= 1'b0;
			status       <= 1'b0;
			read_value   <= '0;
			read_inverse <= '0;
			t_q          <= '0;
			cp_v_s1      <= 1'b0;
			mv_v_s1      <= 1'b0;
		end else begin
			done    <= 1'b0;
			cp_v_s1 <= 1'b0;
			mv_v_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						read_value   <= '0;
						read_inverse <= '0;
						status       <= bad_c;
						if (bad_c || op == OP_LOAD) begin
							done <= 1'b1;
						end else if (op == OP_READ) begin
							state_q <= ST_RDWAIT;
						end else begin
							t_q     <= lo_c[POS_W-1:0];
							state_q <= ST_COPY;
						end
					end
				end
				ST_RDWAIT: begin
					done         <= 1'b1;
					read_value   <= elem_rdata;
					read_inverse <= inv_rdata;
					state_q      <= ST_IDLE;
				end
				ST_COPY: begin
					cp_v_s1 <= 1'b1;
					if (t_q == hi_q) begin
						state_q <= ST_GAP;
					end else begin
						t_q <= t_q + 7'd1;
					end
				end
				ST_GAP: begin
					// last scratch write lands here before the read-back starts
					t_q     <= lo_q;
					state_q <= ST_MOVE;
				end
				ST_MOVE: begin
					mv_v_s1 <= 1'b1;
					if (t_q == hi_q) begin
						state_q <= ST_FIN;
					end else begin
						t_q <= t_q + 7'd1;
					end
				end
				ST_FIN: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hdl/pre_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
